>>> rtl/core/ptsf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// Package for the peer table sequence filter.
// Holds the verdict codes, the sequence wrap value and the table entry types.
// No dependencies.
package ptsf_pkg;

    // Verdict codes reported with every request.
    typedef enum logic [2:0] {
        V_NEW       = 3'd0,
        V_IN_ORDER  = 3'd1,
        V_GAP       = 3'd2,
        V_DUPLICATE = 3'd3,
        V_FULL      = 3'd4
    } t_verdict;

    localparam int unsigned KEY_W = 96;
    localparam int unsigned SEQ_W = 32;
    localparam int unsigned IDX_W = 4;

    // Highest sequence number; the next one after it is zero.
    localparam logic [SEQ_W-1:0] SEQ_WRAP_VALUE = 32'hFFFF_FFFF;

    // One table entry: sender id and last sequence number.
    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic [SEQ_W-1:0] seq;
    } t_tbl_ent;

    // Write request into the table.
    typedef struct packed {
        logic     en;
        t_tbl_ent ent;
    } t_tbl_wr;

endpackage : ptsf_pkg
`default_nettype wire

>>> rtl/core/ptsf_in_if.sv
`timescale 1ns / 1ps
`default_nettype none
// Request channel of the peer table sequence filter: message header in.
// Valid/ready handshake; no dependencies.
interface ptsf_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] sender_wafer;
    logic [31:0] sender_lot;
    logic [31:0] sender_coordinate;
    logic [31:0] sequence_number;

    modport source (
        output valid, sender_wafer, sender_lot, sender_coordinate, sequence_number,
        input  ready
    );
    modport sink (
        input  valid, sender_wafer, sender_lot, sender_coordinate, sequence_number,
        output ready
    );
endinterface : ptsf_in_if
`default_nettype wire

>>> rtl/core/ptsf_out_if.sv
`timescale 1ns / 1ps
`default_nettype none
// Result channel of the peer table sequence filter: verdict per request.
// Valid/ready handshake; no dependencies.
interface ptsf_out_if;
    logic       valid;
    logic       ready;
    logic [2:0] verdict;
    logic [3:0] entry_index;
    logic       accept;

    modport source (
        output valid, verdict, entry_index, accept,
        input  ready
    );
    modport sink (
        input  valid, verdict, entry_index, accept,
        output ready
    );
endinterface : ptsf_out_if
`default_nettype wire

>>> rtl/core/ptsf_table.sv
`timescale 1ns / 1ps
`default_nettype none
// Peer table storage: sender ids and last sequence numbers in one memory,
// with a valid bit per entry so that an unwritten entry reads as empty.
// Depends on ptsf_pkg.
module ptsf_table #(
    parameter int unsigned PEER_ENTRIES = 16,
    parameter int unsigned AW           = 4
) (
    input  wire                logic     i_clk,
    input  wire                logic     i_rst_n,
    input  wire                logic     i_rd_en,
    input  wire                logic [AW-1:0] i_rd_addr,
    output ptsf_pkg::t_tbl_ent           o_rd,
    input  wire ptsf_pkg::t_tbl_wr       i_wr,
    input  wire                logic [AW-1:0] i_wr_addr
);
    import ptsf_pkg::*;

    t_tbl_ent                r_mem [PEER_ENTRIES];
    logic [PEER_ENTRIES-1:0] r_valid;
    t_tbl_ent                r_rd;

    // Valid bits: cleared at reset, set on the first write to an entry.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_wr.en) begin
            r_valid[i_wr_addr] <= 1'b1;
        end
    end

    // Memory write port.
    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr_addr] <= i_wr.ent;
        end
    end

    // Registered read port; an entry never written reads as all zero.
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            if (r_valid[i_rd_addr]) begin
                r_rd <= r_mem[i_rd_addr];
            end else begin
                r_rd <= '0;
            end
        end
    end

    assign o_rd = r_rd;

endmodule : ptsf_table
`default_nettype wire

>>> rtl/core/peer_table_sequence_filter.sv
`timescale 1ns / 1ps
`default_nettype none
// Peer table sequence filter: top level with the scan sequencer and judge step.
// Depends on ptsf_pkg, ptsf_in_if, ptsf_out_if and ptsf_table.
//
// Each request carries a 96-bit sender id and a 32-bit sequence number. The
// block scans its table of PEER_ENTRIES senders one entry per clock through a
// single registered memory read port and one shared key comparator, stopping
// at the first matching entry. A scan covers the whole table when no entry
// matches and ends sooner when a sender is found early. The block takes one
// request at a time and is ready again once the result is loaded into the
// output register, so a result waiting at the output does not block the next
// request. The table reads as empty right after reset; no clearing pass is needed.
module peer_table_sequence_filter #(
    parameter int unsigned PEER_ENTRIES = 16
) (
    input wire logic i_clk,
    input wire logic i_rst_n,
    ptsf_in_if.sink  i_req,
    ptsf_out_if.source o_rsp
);
    import ptsf_pkg::*;

    localparam int unsigned AW = (PEER_ENTRIES > 1) ? $clog2(PEER_ENTRIES) : 1;
    localparam logic [AW-1:0] LAST_IDX = AW'(PEER_ENTRIES - 1);

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_SCAN  = 4'b0010,
        S_JUDGE = 4'b0100,
        S_DONE  = 4'b1000
    } t_state;

    t_state            r_state;
    logic [KEY_W-1:0]  r_key;
    logic [SEQ_W-1:0]  r_seq;
    logic [AW-1:0]     r_addr;
    logic              r_issue_done;
    logic              r_rd_live;
    logic [AW-1:0]     r_rd_idx;
    logic              r_empty_found;
    logic [AW-1:0]     r_empty_idx;
    logic              r_hit;
    logic [AW-1:0]     r_hit_idx;
    logic [SEQ_W-1:0]  r_last;
    t_verdict          r_verdict;
    logic [AW-1:0]     r_res_idx;
    logic              r_out_valid;
    t_verdict          r_out_verdict;
    logic [IDX_W-1:0]  r_out_idx;
    logic              r_out_accept;

    logic              req_take;
    logic              rd_en;
    t_tbl_ent          rd_ent;
    logic              rd_match;
    logic              rd_empty;
    t_tbl_wr           wr;
    logic [AW-1:0]     wr_addr;
    t_verdict          judge_verdict;
    logic [SEQ_W-1:0]  last_plus_one;
    logic              seq_not_above;
    logic              out_load;
    logic [AW+IDX_W-1:0] res_idx_ext;

    assign i_req.ready = (r_state == S_IDLE);
    assign req_take    = i_req.valid && i_req.ready;
    assign rd_en       = (r_state == S_SCAN) && !r_issue_done;

    // Table storage with one read and one write port.
    ptsf_table #(
        .PEER_ENTRIES (PEER_ENTRIES),
        .AW           (AW)
    ) u_table (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (rd_en),
        .i_rd_addr (r_addr),
        .o_rd      (rd_ent),
        .i_wr      (wr),
        .i_wr_addr (wr_addr)
    );

    // Shared key comparator on the entry that just came out of the table.
    assign rd_match = (rd_ent.key == r_key);
    assign rd_empty = (rd_ent.key == '0);

    // Sequence judge for a known sender.
    assign last_plus_one = r_last + 32'd1;
    assign seq_not_above = (r_seq <= r_last);

    always_comb begin
        if (r_last == SEQ_WRAP_VALUE) begin
            if (r_seq == SEQ_WRAP_VALUE) begin
                judge_verdict = V_DUPLICATE;
            end else if (r_seq == '0) begin
                judge_verdict = V_IN_ORDER;
            end else begin
                judge_verdict = V_GAP;
            end
        end else if (r_seq == last_plus_one) begin
            judge_verdict = V_IN_ORDER;
        end else if (seq_not_above) begin
            judge_verdict = V_DUPLICATE;
        end else begin
            judge_verdict = V_GAP;
        end
    end

    // Table update in the judge step: accepted numbers and new senders.
    always_comb begin
        wr.en      = 1'b0;
        wr.ent.key = r_key;
        wr.ent.seq = r_seq;
        wr_addr    = r_hit_idx;
        if (r_state == S_JUDGE) begin
            if (r_hit) begin
                wr.en = (judge_verdict != V_DUPLICATE);
            end else if (r_empty_found) begin
                wr.en   = 1'b1;
                wr_addr = r_empty_idx;
            end
        end
    end

    assign out_load = (r_state == S_DONE) && (!r_out_valid || o_rsp.ready);

    // Sequencer: capture, scan, judge, hand over to the output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_rd_live <= 1'b0;
        end else begin
            r_rd_live <= rd_en;
            case (r_state)
                S_IDLE: begin
                    if (req_take) begin
                        r_state <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    if (r_rd_live && (rd_match || r_rd_idx == LAST_IDX)) begin
                        r_state <= S_JUDGE;
                    end
                end
                S_JUDGE: begin
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    if (out_load) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // Request capture and scan bookkeeping.
    always_ff @(posedge i_clk) begin
        if (req_take) begin
            r_key         <= {i_req.sender_wafer, i_req.sender_lot, i_req.sender_coordinate};
            r_seq         <= i_req.sequence_number;
            r_addr        <= '0;
            r_issue_done  <= 1'b0;
            r_empty_found <= 1'b0;
            r_hit         <= 1'b0;
        end else if (r_state == S_SCAN) begin
            if (rd_en) begin
                r_rd_idx <= r_addr;
                if (r_addr == LAST_IDX) begin
                    r_issue_done <= 1'b1;
                end else begin
                    r_addr <= r_addr + 1'b1;
                end
            end
            if (r_rd_live) begin
                if (rd_match) begin
                    r_hit     <= 1'b1;
                    r_hit_idx <= r_rd_idx;
                    r_last    <= rd_ent.seq;
                end else if (rd_empty && !r_empty_found) begin
                    r_empty_found <= 1'b1;
                    r_empty_idx   <= r_rd_idx;
                end
            end
        end
    end

    // Verdict and entry index of the finished request.
    always_ff @(posedge i_clk) begin
        if (r_state == S_JUDGE) begin
            if (r_hit) begin
                r_verdict <= judge_verdict;
                r_res_idx <= r_hit_idx;
            end else if (r_empty_found) begin
                r_verdict <= V_NEW;
                r_res_idx <= r_empty_idx;
            end else begin
                r_verdict <= V_FULL;
                r_res_idx <= '0;
            end
        end
    end

    assign res_idx_ext = {{IDX_W{1'b0}}, r_res_idx};

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_verdict <= r_verdict;
            r_out_idx     <= res_idx_ext[IDX_W-1:0];
            r_out_accept  <= (r_verdict == V_NEW) || (r_verdict == V_IN_ORDER) ||
                             (r_verdict == V_GAP);
        end
    end

    assign o_rsp.valid       = r_out_valid;
    assign o_rsp.verdict     = r_out_verdict;
    assign o_rsp.entry_index = r_out_idx;
    assign o_rsp.accept      = r_out_accept;

    // A table full result always reports entry zero and is not accepted.
    a_full_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && o_rsp.verdict == V_FULL) |-> (o_rsp.entry_index == '0 && !o_rsp.accept))
        else $error("table full result with nonzero index or accept");

    // Only accepted verdicts carry the accept flag.
    a_accept_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.valid |-> (o_rsp.accept == (o_rsp.verdict == V_NEW ||
                         o_rsp.verdict == V_IN_ORDER || o_rsp.verdict == V_GAP)))
        else $error("accept flag disagrees with verdict");

    // The table is written only in the judge step and never for a duplicate.
    a_write_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        wr.en |-> (r_state == S_JUDGE && !(r_hit && judge_verdict == V_DUPLICATE)))
        else $error("table write outside the judge step");

    // A taken request starts a scan from the first entry.
    a_scan_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        req_take |=> (r_state == S_SCAN && r_addr == '0 && !r_issue_done))
        else $error("scan did not start after a request");

endmodule : peer_table_sequence_filter
`default_nettype wire

>>> test/ptsf_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// Checker for the peer table sequence filter: it watches both channels,
// predicts every verdict from its own sender table and compares the results.
// Depends on ptsf_pkg.
module ptsf_checker #(
    parameter int unsigned N_ENTRIES = 16
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_req_valid,
    input  wire logic        i_req_ready,
    input  wire logic [31:0] i_req_wafer,
    input  wire logic [31:0] i_req_lot,
    input  wire logic [31:0] i_req_coordinate,
    input  wire logic [31:0] i_req_sequence,
    input  wire logic        i_rsp_valid,
    input  wire logic        i_rsp_ready,
    input  wire logic [2:0]  i_rsp_verdict,
    input  wire logic [3:0]  i_rsp_entry,
    input  wire logic        i_rsp_accept,
    output int               o_fail_count,
    output int               o_pending,
    output int               o_result_count,
    output int               o_new_count,
    output int               o_order_count,
    output int               o_gap_count,
    output int               o_dup_count,
    output int               o_full_count
);
    import ptsf_pkg::*;

    // Expected outcome of one request.
    typedef struct packed {
        t_verdict         verdict;
        logic [IDX_W-1:0] entry;
        logic             accept;
    } t_outcome;

    // Mirror of the sender table.
    logic [KEY_W-1:0] known_id [N_ENTRIES];
    logic [SEQ_W-1:0] last_seq [N_ENTRIES];

    t_outcome outcome_q [$];
    t_outcome due;
    int       fail_tally = 0;
    int       tally_new = 0;
    int       tally_order = 0;
    int       tally_gap = 0;
    int       tally_dup = 0;
    int       tally_full = 0;
    int       results = 0;

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("[%0t] result %0d, %s: got %0d, expected %0d",
                 $time, results, what, got, want);
        fail_tally++;
    endtask

    // Judge one message header against the table and update the table.
    function automatic t_outcome judge_header(input logic [KEY_W-1:0] id,
                                              input logic [SEQ_W-1:0] seq);
        t_outcome         res;
        logic [SEQ_W-1:0] last;
        int unsigned      hit;
        bit               found;
        found = 1'b0;
        hit   = 0;
        for (int e = 0; e < N_ENTRIES; e++) begin
            if (!found && known_id[e] == id) begin
                found = 1'b1;
                hit   = e;
            end
        end
        if (found) begin
            last = last_seq[hit];
            if (last == SEQ_WRAP_VALUE) begin
                if (seq == SEQ_WRAP_VALUE) res.verdict = V_DUPLICATE;
                else if (seq == '0)        res.verdict = V_IN_ORDER;
                else                       res.verdict = V_GAP;
            end else begin
                if (seq == last + 1'b1)    res.verdict = V_IN_ORDER;
                else if (seq <= last)      res.verdict = V_DUPLICATE;
                else                       res.verdict = V_GAP;
            end
            if (res.verdict != V_DUPLICATE) last_seq[hit] = seq;
        end else begin
            // Unknown sender takes the lowest empty entry, if there is one.
            res.verdict = V_FULL;
            for (int e = 0; e < N_ENTRIES; e++) begin
                if (res.verdict == V_FULL && known_id[e] == '0) begin
                    known_id[e] = id;
                    last_seq[e] = seq;
                    res.verdict = V_NEW;
                    hit         = e;
                end
            end
            if (res.verdict == V_FULL) hit = 0;
        end
        res.entry  = IDX_W'(hit);
        res.accept = (res.verdict == V_NEW || res.verdict == V_IN_ORDER ||
                      res.verdict == V_GAP);
        return res;
    endfunction

    // Predict on every accepted request, compare on every accepted result.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int e = 0; e < N_ENTRIES; e++) begin
                known_id[e] = '0;
                last_seq[e] = '0;
            end
            outcome_q.delete();
        end else begin
            if (i_req_valid && i_req_ready) begin
                outcome_q.push_back(judge_header({i_req_wafer, i_req_lot, i_req_coordinate},
                                                 i_req_sequence));
            end
            if (i_rsp_valid && i_rsp_ready) begin
                results++;
                if (outcome_q.size() == 0) begin
                    report_mismatch("result with no request waiting", i_rsp_verdict, 0);
                end else begin
                    due = outcome_q.pop_front();
                    if (i_rsp_verdict !== due.verdict)
                        report_mismatch("verdict", i_rsp_verdict, due.verdict);
                    if (i_rsp_entry !== due.entry)
                        report_mismatch("entry index", i_rsp_entry, due.entry);
                    if (i_rsp_accept !== due.accept)
                        report_mismatch("accept", i_rsp_accept, due.accept);
                    case (due.verdict)
                        V_NEW:       tally_new++;
                        V_IN_ORDER:  tally_order++;
                        V_GAP:       tally_gap++;
                        V_DUPLICATE: tally_dup++;
                        default:     tally_full++;
                    endcase
                end
            end
        end
        o_fail_count   <= fail_tally;
        o_pending      <= outcome_q.size();
        o_result_count <= results;
        o_new_count    <= tally_new;
        o_order_count  <= tally_order;
        o_gap_count    <= tally_gap;
        o_dup_count    <= tally_dup;
        o_full_count   <= tally_full;
    end

endmodule : ptsf_checker
`default_nettype wire

>>> test/testbench.sv
`timescale 1ns / 1ps
`default_nettype none
// Top of the peer table sequence filter test: clock, reset, request stimulus,
// result back-pressure, watchdog and verdict.
// Depends on ptsf_pkg, ptsf_in_if, ptsf_out_if, the filter and ptsf_checker.
module testbench;
    import ptsf_pkg::*;

    localparam int unsigned TABLE_DEPTH = 16;
    localparam int          RANDOM_REQUESTS = 1600;
    localparam int          POOL_SIZE = 20;
    localparam int          IDLE_LIMIT = 4000;
    localparam int          DRAIN_CYCLES = 40;
    localparam int          HOLD_START = 3000;
    localparam int          HOLD_CYCLES = 400;

    typedef enum int {RX_FREE, RX_COIN, RX_SPARSE, RX_SLOW} t_rx_mode;
    typedef enum int {SEQ_NEXT, SEQ_REPEAT, SEQ_SKIP, SEQ_NEAR_WRAP} t_seq_move;

    logic i_clk = 1'b0;
    logic i_rst_n;

    ptsf_in_if  req_if ();
    ptsf_out_if rsp_if ();

    int fail_count, pending, result_count;
    int new_count, order_count, gap_count, dup_count, full_count;

    // Senders used for well-formed sequences and the last number sent to each.
    logic [KEY_W-1:0] pool_id   [POOL_SIZE];
    logic [SEQ_W-1:0] pool_last [POOL_SIZE];
    bit               pool_live [POOL_SIZE];

    peer_table_sequence_filter #(
        .PEER_ENTRIES(TABLE_DEPTH)
    ) u_dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (req_if),
        .o_rsp  (rsp_if)
    );

    ptsf_checker #(
        .N_ENTRIES(TABLE_DEPTH)
    ) u_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_req_valid     (req_if.valid),
        .i_req_ready     (req_if.ready),
        .i_req_wafer     (req_if.sender_wafer),
        .i_req_lot       (req_if.sender_lot),
        .i_req_coordinate(req_if.sender_coordinate),
        .i_req_sequence  (req_if.sequence_number),
        .i_rsp_valid     (rsp_if.valid),
        .i_rsp_ready     (rsp_if.ready),
        .i_rsp_verdict   (rsp_if.verdict),
        .i_rsp_entry     (rsp_if.entry_index),
        .i_rsp_accept    (rsp_if.accept),
        .o_fail_count    (fail_count),
        .o_pending       (pending),
        .o_result_count  (result_count),
        .o_new_count     (new_count),
        .o_order_count   (order_count),
        .o_gap_count     (gap_count),
        .o_dup_count     (dup_count),
        .o_full_count    (full_count)
    );

    // 10 ns clock.
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Present one request and hold it until the filter takes it.
    task automatic push_header(input logic [31:0] wafer, input logic [31:0] lot,
                               input logic [31:0] coordinate, input logic [31:0] seq);
        @(negedge i_clk);
        req_if.valid             <= 1'b1;
        req_if.sender_wafer      <= wafer;
        req_if.sender_lot        <= lot;
        req_if.sender_coordinate <= coordinate;
        req_if.sequence_number   <= seq;
        do @(posedge i_clk); while (!req_if.ready);
    endtask

    task automatic rest(input int cycles);
        if (cycles > 0) begin
            @(negedge i_clk);
            req_if.valid <= 1'b0;
            repeat (cycles - 1) @(negedge i_clk);
        end
    endtask

    // Mostly plausible traffic from the sender pool, plus unknown and all-zero ids.
    task automatic send_random_header();
        int               roll;
        int               pick;
        logic [SEQ_W-1:0] seq;
        logic [SEQ_W-1:0] last;
        t_seq_move        move;
        roll = $urandom_range(0, 99);
        if (roll < 5) begin
            push_header($urandom, $urandom, $urandom, $urandom);
        end else if (roll < 9) begin
            seq = (roll < 7) ? $urandom : $urandom_range(0, 3);
            push_header('0, '0, '0, seq);
        end else begin
            pick = $urandom_range(0, POOL_SIZE - 1);
            last = pool_last[pick];
            if (!pool_live[pick]) begin
                seq = ($urandom_range(0, 3) == 0) ? SEQ_WRAP_VALUE - $urandom_range(0, 2)
                                                  : $urandom;
                pool_live[pick] = 1'b1;
                pool_last[pick] = seq;
            end else begin
                roll = $urandom_range(0, 9);
                if (roll < 5)      move = SEQ_NEXT;
                else if (roll < 7) move = SEQ_REPEAT;
                else if (roll < 9) move = SEQ_SKIP;
                else               move = SEQ_NEAR_WRAP;
                case (move)
                    SEQ_NEXT: seq = last + 1'b1;
                    SEQ_REPEAT: begin
                        if (last == SEQ_WRAP_VALUE || $urandom_range(0, 1) == 1) seq = last;
                        else seq = $urandom % (last + 1'b1);
                    end
                    SEQ_SKIP: begin
                        seq = last + 32'd2 +
                              (($urandom_range(0, 1) == 1) ? $urandom_range(0, 100)
                                                           : $urandom_range(0, 32'h7FFF_FFFF));
                    end
                    default: seq = SEQ_WRAP_VALUE - $urandom_range(0, 2);
                endcase
                // Only numbers the filter will take move the sender forward.
                if (last == SEQ_WRAP_VALUE ? (seq != SEQ_WRAP_VALUE) : (seq > last))
                    pool_last[pick] = seq;
            end
            push_header(pool_id[pick][95:64], pool_id[pick][63:32], pool_id[pick][31:0], seq);
        end
    endtask

    // Request stimulus: reset, directed headers, then random traffic in bursts.
    initial begin
        int burst_left;
        burst_left = 0;
        i_rst_n                  <= 1'b0;
        req_if.valid             <= 1'b0;
        req_if.sender_wafer      <= '0;
        req_if.sender_lot        <= '0;
        req_if.sender_coordinate <= '0;
        req_if.sequence_number   <= '0;
        for (int i = 0; i < POOL_SIZE; i++) begin
            pool_id[i]   = {$urandom, $urandom, $urandom};
            pool_last[i] = '0;
            pool_live[i] = 1'b0;
        end
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // All-zero id rides on the lowest empty entry, including a wrap.
        push_header('0, '0, '0, 32'd0);
        push_header('0, '0, '0, 32'd1);
        push_header('0, '0, '0, SEQ_WRAP_VALUE);
        push_header('0, '0, '0, 32'd0);
        // All-ones sender: wrap handling from the top value and ordinary steps.
        push_header('1, '1, '1, SEQ_WRAP_VALUE);
        push_header('1, '1, '1, SEQ_WRAP_VALUE);
        push_header('1, '1, '1, 32'd0);
        push_header('1, '1, '1, 32'd0);
        push_header('1, '1, '1, 32'd9);
        push_header('1, '1, '1, 32'd10);
        push_header('1, '1, '1, 32'd3);
        push_header('1, '1, '1, 32'hFFFF_FFFE);
        push_header('1, '1, '1, SEQ_WRAP_VALUE);
        push_header('1, '1, '1, 32'd77);
        push_header('0, '0, '0, 32'd5);
        // Single-bit ids in the first and the last word and a mixed one.
        push_header(32'd1, '0, '0, 32'd0);
        push_header(32'd1, '0, '0, 32'd1);
        push_header('0, '0, 32'h8000_0000, 32'h1234_5678);
        push_header('0, '0, 32'h8000_0000, 32'h1234_5678);
        push_header(32'h8000_0000, 32'hFFFF_0000, 32'h0000_FFFF, SEQ_WRAP_VALUE);
        push_header(32'h8000_0000, 32'hFFFF_0000, 32'h0000_FFFF, 32'd0);
        push_header(32'h8000_0000, 32'hFFFF_0000, 32'h0000_FFFF, SEQ_WRAP_VALUE);

        for (int n = 0; n < RANDOM_REQUESTS; n++) begin
            if (n == 600 || n == 1200) begin
                // Let the filter drain completely before going on.
                rest(1);
                while (pending != 0) @(negedge i_clk);
            end
            if (burst_left == 0) begin
                rest($urandom_range(0, 10));
                burst_left = $urandom_range(1, 24);
            end
            burst_left--;
            send_random_header();
        end
        rest(1);

        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        $display("Checked %0d results: %0d new senders, %0d in order, %0d gaps,",
                 result_count, new_count, order_count, gap_count);
        $display("%0d duplicates and %0d turned away by a full table.",
                 dup_count, full_count);
        if (fail_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    // Result back-pressure: changing stall patterns plus one long hold.
    initial begin
        int unsigned rx_cycle;
        int          mode_left;
        int          hold_left;
        t_rx_mode    mode;
        rx_cycle  = 0;
        mode_left = 0;
        hold_left = 0;
        mode      = RX_FREE;
        rsp_if.ready <= 1'b0;
        forever begin
            @(negedge i_clk);
            rx_cycle++;
            if (rx_cycle == HOLD_START) hold_left = HOLD_CYCLES;
            if (hold_left > 0) begin
                hold_left--;
                rsp_if.ready <= 1'b0;
            end else begin
                if (mode_left == 0) begin
                    mode      = t_rx_mode'($urandom_range(0, 3));
                    mode_left = $urandom_range(32, 256);
                end
                mode_left--;
                case (mode)
                    RX_FREE:   rsp_if.ready <= 1'b1;
                    RX_COIN:   rsp_if.ready <= 1'($urandom_range(0, 1));
                    RX_SPARSE: rsp_if.ready <= (rx_cycle % 4 == 0);
                    default:   rsp_if.ready <= ($urandom_range(0, 15) == 0);
                endcase
            end
        end
    end

    // Watchdog on cycles in which neither channel moves.
    always @(posedge i_clk) begin
        int idle_cycles;
        if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("Timeout after %0d quiet cycles", idle_cycles);
                $display("Mismatches found");
                $finish;
            end
        end
    end

endmodule : testbench
`default_nettype wire
